@@ sv/crov_pkg.sv @@
// shared types and constants for the circle / rectangle overlap pipeline
// no dependencies; imported by every module of the block
package crov_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int RAD_WIDTH   = COORD_WIDTH - 1;

    typedef enum logic [1:0] {
        KIND_CIRCLE = 2'd0,
        KIND_RECT   = 2'd1,
        KIND_AREA   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // shape as it arrives on the ports
    typedef struct packed {
        logic [1:0]                    kind;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] x2;
        logic signed [COORD_WIDTH-1:0] y2;
        logic [RAD_WIDTH-1:0]          r;
    } raw_shape_t;

    // shape with sorted corners; circles carry the centre in both corners
    typedef struct packed {
        kind_t                         kind;
        logic signed [COORD_WIDTH-1:0] x0;
        logic signed [COORD_WIDTH-1:0] y0;
        logic signed [COORD_WIDTH-1:0] x1;
        logic signed [COORD_WIDTH-1:0] y1;
        logic [RAD_WIDTH-1:0]          r;
    } shape_t;

    typedef struct packed {
        shape_t a;
        shape_t b;
    } pair_t;

    // distance test operands plus any decision already made
    typedef struct packed {
        logic                        direct_hit;
        logic                        use_dist;
        logic signed [COORD_WIDTH:0] dx;
        logic signed [COORD_WIDTH:0] dy;
        logic [COORD_WIDTH-1:0]      rs;
    } geo_t;

    typedef struct packed {
        logic                     direct_hit;
        logic                     use_dist;
        logic [2*COORD_WIDTH-1:0] dx2;
        logic [2*COORD_WIDTH-1:0] dy2;
        logic [2*COORD_WIDTH-1:0] rs2;
    } sq_t;

endpackage

@@ sv/crov_load.sv @@
// stage 1: corner sorting of both shapes
// depends on crov_pkg
module crov_load (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_stall,
    input  crov_pkg::raw_shape_t raw_a,
    input  crov_pkg::raw_shape_t raw_b,
    output logic                dn_valid,
    input  logic                dn_stall,
    output crov_pkg::pair_t     pair
);
    import crov_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    pair_t pair_reg;
    pair_t pair_next;

    function automatic shape_t norm(input raw_shape_t s);
        shape_t o;
        o.kind = kind_t'(s.kind);
        o.r    = s.r;
        if (kind_t'(s.kind) == KIND_RECT)
        begin
            o.x0 = (s.x < s.x2) ? s.x : s.x2;
            o.x1 = (s.x < s.x2) ? s.x2 : s.x;
            o.y0 = (s.y < s.y2) ? s.y : s.y2;
            o.y1 = (s.y < s.y2) ? s.y2 : s.y;
        end
        else
        begin
            o.x0 = s.x;
            o.x1 = s.x;
            o.y0 = s.y;
            o.y1 = s.y;
        end
        return o;
    endfunction

    assign up_stall = valid_reg & dn_stall;

    always_comb
    begin
        valid_next  = up_stall ? valid_reg : up_valid;
        pair_next.a = norm(raw_a);
        pair_next.b = norm(raw_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            pair_reg <= pair_next;
        end
    end

    assign dn_valid = valid_reg;
    assign pair     = pair_reg;
endmodule

@@ sv/crov_geom.sv @@
// stage 2: clamping, containment and edge crossing, distance operands
// depends on crov_pkg
module crov_geom (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_stall,
    input  crov_pkg::pair_t pair,
    output logic            dn_valid,
    input  logic            dn_stall,
    output crov_pkg::geo_t  geo
);
    import crov_pkg::*;

    logic valid_reg;
    logic valid_next;
    geo_t geo_reg;
    geo_t geo_next;

    shape_t                        c;
    shape_t                        r;
    logic                          both_circ;
    logic                          circ_rect;
    logic                          rect_pair;
    logic signed [COORD_WIDTH-1:0] nx;
    logic signed [COORD_WIDTH-1:0] ny;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic                          c_in_r;

    function automatic logic in_box(input logic signed [COORD_WIDTH-1:0] x,
                                    input logic signed [COORD_WIDTH-1:0] y,
                                    input shape_t s);
        return (x >= s.x0) && (x <= s.x1) && (y >= s.y0) && (y <= s.y1);
    endfunction

    // horizontal edges of h strictly crossing vertical edges of v
    function automatic logic crossing(input shape_t h, input shape_t v);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                if ((h.x0 < (j == 0 ? v.x0 : v.x1)) && ((j == 0 ? v.x0 : v.x1) < h.x1) &&
                    (v.y0 < (i == 0 ? h.y0 : h.y1)) && ((i == 0 ? h.y0 : h.y1) < v.y1))
                begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    assign up_stall = valid_reg & dn_stall;

    always_comb
    begin
        both_circ = (pair.a.kind == KIND_CIRCLE) && (pair.b.kind == KIND_CIRCLE);
        circ_rect = ((pair.a.kind == KIND_CIRCLE) && (pair.b.kind == KIND_RECT)) ||
                    ((pair.a.kind == KIND_RECT) && (pair.b.kind == KIND_CIRCLE));
        rect_pair = (pair.a.kind == KIND_RECT) && (pair.b.kind == KIND_RECT);
        c = (pair.a.kind == KIND_CIRCLE) ? pair.a : pair.b;
        r = (pair.a.kind == KIND_CIRCLE) ? pair.b : pair.a;

        // nearest point of the rectangle to the centre
        nx = (c.x0 < r.x0) ? r.x0 : ((c.x0 > r.x1) ? r.x1 : c.x0);
        ny = (c.y0 < r.y0) ? r.y0 : ((c.y0 > r.y1) ? r.y1 : c.y0);
        c_in_r = in_box(c.x0, c.y0, r);

        px = both_circ ? pair.b.x0 : nx;
        py = both_circ ? pair.b.y0 : ny;

        geo_next.dx = {c.x0[COORD_WIDTH-1], c.x0} - {px[COORD_WIDTH-1], px};
        geo_next.dy = {c.y0[COORD_WIDTH-1], c.y0} - {py[COORD_WIDTH-1], py};
        geo_next.rs = both_circ ? ({1'b0, pair.a.r} + {1'b0, pair.b.r}) : {1'b0, c.r};
        geo_next.use_dist   = both_circ | circ_rect;
        geo_next.direct_hit = (circ_rect & c_in_r) |
                              (rect_pair & (crossing(pair.a, pair.b) |
                                            crossing(pair.b, pair.a) |
                                            in_box(pair.a.x0, pair.a.y0, pair.b) |
                                            in_box(pair.b.x0, pair.b.y0, pair.a)));
        valid_next = up_stall ? valid_reg : up_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            geo_reg <= geo_next;
        end
    end

    assign dn_valid = valid_reg;
    assign geo      = geo_reg;
endmodule

@@ sv/crov_square.sv @@
// stage 3: magnitudes and the three squarers
// depends on crov_pkg
module crov_square (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_stall,
    input  crov_pkg::geo_t geo,
    output logic           dn_valid,
    input  logic           dn_stall,
    output crov_pkg::sq_t  sq
);
    import crov_pkg::*;

    logic valid_reg;
    logic valid_next;
    sq_t  sq_reg;
    sq_t  sq_next;

    logic [COORD_WIDTH:0]   tx;
    logic [COORD_WIDTH:0]   ty;
    logic [COORD_WIDTH-1:0] adx;
    logic [COORD_WIDTH-1:0] ady;

    assign up_stall = valid_reg & dn_stall;

    always_comb
    begin
        // a difference of two coordinates always has a magnitude below 2**COORD_WIDTH
        tx  = geo.dx[COORD_WIDTH] ? (~geo.dx + 1'b1) : geo.dx;
        ty  = geo.dy[COORD_WIDTH] ? (~geo.dy + 1'b1) : geo.dy;
        adx = tx[COORD_WIDTH-1:0];
        ady = ty[COORD_WIDTH-1:0];
        sq_next.dx2 = {{COORD_WIDTH{1'b0}}, adx} * {{COORD_WIDTH{1'b0}}, adx};
        sq_next.dy2 = {{COORD_WIDTH{1'b0}}, ady} * {{COORD_WIDTH{1'b0}}, ady};
        sq_next.rs2 = {{COORD_WIDTH{1'b0}}, geo.rs} * {{COORD_WIDTH{1'b0}}, geo.rs};
        sq_next.direct_hit = geo.direct_hit;
        sq_next.use_dist   = geo.use_dist;
        valid_next = up_stall ? valid_reg : up_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            sq_reg <= sq_next;
        end
    end

    assign dn_valid = valid_reg;
    assign sq       = sq_reg;
endmodule

@@ sv/crov_decide.sv @@
// stage 4: squared distance sum, compare and the output register
// depends on crov_pkg
module crov_decide (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_stall,
    input  crov_pkg::sq_t sq,
    output logic          dn_valid,
    input  logic          dn_stall,
    output logic          hit
);
    import crov_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic                   hit_reg;
    logic                   hit_next;
    logic [2*COORD_WIDTH:0] d2;

    assign up_stall = valid_reg & dn_stall;

    always_comb
    begin
        d2       = {1'b0, sq.dx2} + {1'b0, sq.dy2};
        hit_next = sq.direct_hit | (sq.use_dist & (d2 < {1'b0, sq.rs2}));
        valid_next = up_stall ? valid_reg : up_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            hit_reg <= hit_next;
        end
    end

    assign dn_valid = valid_reg;
    assign hit      = hit_reg;
endmodule

@@ sv/circle_rectangle_overlap_test.sv @@
// Overlap test for pairs of planar shapes (circle or axis-parallel rectangle),
// one transaction in and one overlap flag out per pair. The block is a four-stage
// pipeline: corner sorting, clamping / containment / edge crossing, the squarers,
// and the distance compare that feeds the output register. A new pair is taken
// every cycle while item_stall is low. Every stage holds its item while the stage
// after it is full and stalled, so bubbles close up and item_stall rises only
// when all four stages hold work and result_stall is high. Area and none kinds
// give 0.
// depends on crov_pkg and the crov stage modules
module circle_rectangle_overlap_test (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel: one shape pair per transaction
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [1:0]                           a_kind,
    input  logic signed [crov_pkg::COORD_WIDTH-1:0] a_x,
    input  logic signed [crov_pkg::COORD_WIDTH-1:0] a_y,
    input  logic signed [crov_pkg::COORD_WIDTH-1:0] a_x2,
    input  logic signed [crov_pkg::COORD_WIDTH-1:0] a_y2,
    input  logic [crov_pkg::RAD_WIDTH-1:0]       a_radius,
    input  logic [1:0]                           b_kind,
    input  logic signed [crov_pkg::COORD_WIDTH-1:0] b_x,
    input  logic signed [crov_pkg::COORD_WIDTH-1:0] b_y,
    input  logic signed [crov_pkg::COORD_WIDTH-1:0] b_x2,
    input  logic signed [crov_pkg::COORD_WIDTH-1:0] b_y2,
    input  logic [crov_pkg::RAD_WIDTH-1:0]       b_radius,
    // output channel: one flag per transaction
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic                                 overlap
);
    import crov_pkg::*;

    raw_shape_t raw_a;
    raw_shape_t raw_b;
    pair_t      pair;
    geo_t       geo;
    sq_t        sq;

    // stage valids and the stall that each stage sends upstream
    logic s1_valid;
    logic s2_valid;
    logic s3_valid;
    logic s2_stall;
    logic s3_stall;
    logic s4_stall;

    // pack the port fields into shape records
    assign raw_a = '{kind: a_kind, x: a_x, y: a_y, x2: a_x2, y2: a_y2, r: a_radius};
    assign raw_b = '{kind: b_kind, x: b_x, y: b_y, x2: b_x2, y2: b_y2, r: b_radius};

    // stage 1: order the rectangle corners
    crov_load u_load (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (item_valid),
        .up_stall (item_stall),
        .raw_a    (raw_a),
        .raw_b    (raw_b),
        .dn_valid (s1_valid),
        .dn_stall (s2_stall),
        .pair     (pair)
    );

    // stage 2: rectangle tests settle here, distance operands for the rest
    crov_geom u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_stall (s2_stall),
        .pair     (pair),
        .dn_valid (s2_valid),
        .dn_stall (s3_stall),
        .geo      (geo)
    );

    // stage 3: squares of the offsets and of the radius
    crov_square u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_stall (s3_stall),
        .geo      (geo),
        .dn_valid (s3_valid),
        .dn_stall (s4_stall),
        .sq       (sq)
    );

    // stage 4: compare and hold the result until it is taken
    crov_decide u_decide (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_stall (s4_stall),
        .sq       (sq),
        .dn_valid (result_valid),
        .dn_stall (result_stall),
        .hit      (overlap)
    );

`ifndef SYNTHESIS
    // the input only stalls with every stage full and the output blocked
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid && s2_valid && s3_valid && result_valid && result_stall))
        else $error("input stalled with room in the pipeline");

    // an open output register takes exactly what stage 3 offered
    a_out_follow: assert property (@(posedge clk) disable iff (!rst_n)
        !(result_valid && result_stall) |=> (result_valid == $past(s3_valid)))
        else $error("output valid lost or invented a transaction");

    // stage 3 holds its item while the output side cannot take it
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid && result_valid && result_stall) |=> s3_valid)
        else $error("stage 3 dropped a stalled transaction");
`endif
endmodule
